[design/fpp_pkg.sv]
`timescale 1ns / 1ps

package fpp_pkg;

  // payload store geometry
  localparam int PAYLOAD_DEPTH = 64;
  localparam int ADDR_W        = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int LEN_W         = 7;
  localparam int CNT_W         = 32;
  localparam int NUM_CNT       = 5;

  // event counter slots
  localparam int CNT_DISCARD = 0;
  localparam int CNT_LENERR  = 1;
  localparam int CNT_CRCERR  = 2;
  localparam int CNT_VERERR  = 3;
  localparam int CNT_VALID   = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_SOF_FIRST   = 2'd0;
  localparam logic [1:0] CFG_SOF_SECOND  = 2'd1;
  localparam logic [1:0] CFG_EXP_VERSION = 2'd2;
  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd3;

  // crc-16 ccitt-false constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_READY  = 3'd1,
    ST_LENERR = 3'd2,
    ST_CRCERR = 3'd3,
    ST_VERERR = 3'd4
  } status_t;

  // one classified byte handed from front to back
  typedef struct packed {
    status_t                         status;
    logic [7:0]                      msg_id;
    logic [7:0]                      sequence_number;
    logic [LEN_W-1:0]                pay_len;
    logic [NUM_CNT-1:0][CNT_W-1:0]   counters;
  } desc_t;

  // payload store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((v & CRC_MSB) != 16'h0000) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

[design/fpp_if.sv]
`timescale 1ns / 1ps

// received byte channel
interface fpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// result channel
interface fpp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  msg_id;
  logic [7:0]  sequence_number;
  logic [6:0]  pay_len;
  logic [7:0]  payload_byte;
  logic        last;
  logic [31:0] discarded_count;
  logic [31:0] length_error_count;
  logic [31:0] crc_error_count;
  logic [31:0] version_error_count;
  logic [31:0] valid_frame_count;

  modport source (
    output valid, output status, output msg_id, output sequence_number,
    output pay_len, output payload_byte, output last,
    output discarded_count, output length_error_count, output crc_error_count,
    output version_error_count, output valid_frame_count,
    input ready
  );
  modport sink (
    input valid, input status, input msg_id, input sequence_number,
    input pay_len, input payload_byte, input last,
    input discarded_count, input length_error_count, input crc_error_count,
    input version_error_count, input valid_frame_count,
    output ready
  );
endinterface

[design/framed_packet_parser_crc16_top.sv]
`timescale 1ns / 1ps

// Framed packet parser with CRC-16/CCITT-FALSE check.
// in_ch carries one received byte per transaction (valid/ready). The front parser
// hunts for the two start-of-frame bytes, reads header, payload and CRC, and takes
// one byte per cycle. Every byte gives one entry in a two-deep queue to the back end.
// out_ch carries results. A byte ending a good frame of payload length L > 0 gives
// L results, one per stored payload byte, with last on the final one; any other
// byte gives one result with last set. Each result carries the five event counters.
// A single result is written into the queue, then loaded into the output register.
// Throughput: one input byte per cycle unless stalled; replay of a good frame does
// one store read, then one load of the output register, for each payload byte.
// The input stalls while the queue is full; payload bytes of a new frame stall
// while a queue entry is pending or the previous frame replays from the store.
// cfg_we/cfg_index/cfg_data write the registers: 0 first SOF, 1 second SOF,
// 2 expected version, 3 maximum payload length.
// Reset (rst_n low, synchronous) restores register defaults, clears the counters and
// restarts the hunt; the store is not cleared and needs no clearing pass.
// When out_ch stalls, the output register holds its result and the queue fills.
module framed_packet_parser_crc16_top
  import fpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  fpp_in_if.sink     in_ch,
  fpp_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  desc_t     q_push_data;
  desc_t     q_head;
  store_wr_t store_wr;
  logic      q_push, q_pop, q_full, q_empty;
  logic      back_busy;
  logic      replay_busy;

  // a pending or running result blocks new payload writes
  assign replay_busy = back_busy || !q_empty;

  fpp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .replay_busy (replay_busy),
    .q_push      (q_push),
    .q_data      (q_push_data),
    .store_wr    (store_wr)
  );

  fpp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  fpp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .store_wr (store_wr),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .busy     (back_busy),
    .out_ch   (out_ch)
  );

endmodule

[design/fpp_front.sv]
`timescale 1ns / 1ps

module fpp_front
  import fpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fpp_in_if.sink      in_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        q_full,
  input  logic        replay_busy,
  output logic        q_push,
  output desc_t       q_data,
  output store_wr_t   store_wr
);

  typedef enum logic [3:0] {
    PH_SOF1, PH_SOF2, PH_VER, PH_MID, PH_SEQ, PH_LEN, PH_PAY, PH_CRCL, PH_CRCH
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [LEN_W-1:0]              pos_r, pos_nxt;
  logic [15:0]                   crc_r, crc_nxt;
  logic [15:0]                   check_r, check_nxt;
  logic [7:0]                    ver_r, ver_nxt;
  logic [7:0]                    mid_r, mid_nxt;
  logic [7:0]                    seq_r, seq_nxt;
  logic [LEN_W-1:0]              len_r, len_nxt;
  logic [NUM_CNT-1:0][CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                    sof_first_r, sof_second_r, exp_ver_r;
  logic [LEN_W-1:0]              max_payload_r;
  logic [LEN_W-1:0]              limit;
  logic [15:0]                   crc_b;
  logic [15:0]                   check_full;
  logic [7:0]                    b;
  logic                          accept;
  status_t                       status;

  assign b      = in_ch.rx_byte;
  // payload bytes also wait while a result is queued or a frame is still replaying
  assign in_ch.ready = !q_full && !((phase_r == PH_PAY) && replay_busy);
  assign accept = in_ch.valid && in_ch.ready;
  assign limit  = (max_payload_r > LEN_W'(PAYLOAD_DEPTH)) ? LEN_W'(PAYLOAD_DEPTH)
                                                          : max_payload_r;
  assign crc_b      = crc_feed(crc_r, b);
  assign check_full = {b, check_r[7:0]};

  // parser next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    check_nxt = check_r;
    ver_nxt   = ver_r;
    mid_nxt   = mid_r;
    seq_nxt   = seq_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    status    = ST_NONE;
    store_wr.en   = 1'b0;
    store_wr.addr = pos_r[ADDR_W-1:0];
    store_wr.data = b;
    unique case (phase_r)
      PH_SOF1: begin
        if (b == sof_first_r) begin
          phase_nxt = PH_SOF2;
        end else begin
          cnt_nxt[CNT_DISCARD] = cnt_r[CNT_DISCARD] + 1'b1;
        end
      end
      PH_SOF2: begin
        if (b == sof_second_r) begin
          phase_nxt = PH_VER;
          crc_nxt   = CRC_INIT;
        end else if (b != sof_first_r) begin
          cnt_nxt[CNT_DISCARD] = cnt_r[CNT_DISCARD] + 1'b1;
          phase_nxt = PH_SOF1;
        end
      end
      PH_VER: begin
        ver_nxt   = b;
        crc_nxt   = crc_b;
        phase_nxt = PH_MID;
      end
      PH_MID: begin
        mid_nxt   = b;
        crc_nxt   = crc_b;
        phase_nxt = PH_SEQ;
      end
      PH_SEQ: begin
        seq_nxt   = b;
        crc_nxt   = crc_b;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        crc_nxt = crc_b;
        pos_nxt = '0;
        if (b > {1'b0, limit}) begin
          len_nxt   = '0;
          cnt_nxt[CNT_LENERR] = cnt_r[CNT_LENERR] + 1'b1;
          phase_nxt = PH_SOF1;
          crc_nxt   = CRC_INIT;
          check_nxt = '0;
          status    = ST_LENERR;
        end else begin
          len_nxt   = b[LEN_W-1:0];
          phase_nxt = (b == 8'h00) ? PH_CRCL : PH_PAY;
        end
      end
      PH_PAY: begin
        store_wr.en = accept;
        pos_nxt = pos_r + 1'b1;
        crc_nxt = crc_b;
        if (pos_nxt >= len_r) begin
          phase_nxt = PH_CRCL;
        end
      end
      PH_CRCL: begin
        check_nxt = {8'h00, b};
        phase_nxt = PH_CRCH;
      end
      PH_CRCH: begin
        if (check_full != crc_r) begin
          cnt_nxt[CNT_CRCERR] = cnt_r[CNT_CRCERR] + 1'b1;
          status = ST_CRCERR;
        end else if (ver_r != exp_ver_r) begin
          cnt_nxt[CNT_VERERR] = cnt_r[CNT_VERERR] + 1'b1;
          status = ST_VERERR;
        end else begin
          cnt_nxt[CNT_VALID] = cnt_r[CNT_VALID] + 1'b1;
          status = ST_READY;
        end
        phase_nxt = PH_SOF1;
        pos_nxt   = '0;
        crc_nxt   = CRC_INIT;
        check_nxt = '0;
      end
      default: begin
        phase_nxt = PH_SOF1;
        pos_nxt   = '0;
        crc_nxt   = CRC_INIT;
        check_nxt = '0;
      end
    endcase
  end

  // one transaction into the queue for every accepted byte
  always_comb begin
    q_push = accept;
    q_data.status          = status;
    q_data.msg_id          = (status == ST_READY) ? mid_r : 8'h00;
    q_data.sequence_number = (status == ST_READY) ? seq_r : 8'h00;
    q_data.pay_len         = (status == ST_READY) ? len_r : '0;
    q_data.counters        = cnt_nxt;
  end

  // parser state, counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SOF1;
      pos_r         <= '0;
      crc_r         <= CRC_INIT;
      check_r       <= '0;
      ver_r         <= '0;
      mid_r         <= '0;
      seq_r         <= '0;
      len_r         <= '0;
      cnt_r         <= '0;
      sof_first_r   <= 8'hAA;
      sof_second_r  <= 8'h55;
      exp_ver_r     <= 8'h01;
      max_payload_r <= 7'd64;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        crc_r   <= crc_nxt;
        check_r <= check_nxt;
        ver_r   <= ver_nxt;
        mid_r   <= mid_nxt;
        seq_r   <= seq_nxt;
        len_r   <= len_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SOF_FIRST:   sof_first_r   <= cfg_data;
          CFG_SOF_SECOND:  sof_second_r  <= cfg_data;
          CFG_EXP_VERSION: exp_ver_r     <= cfg_data;
          CFG_MAX_PAYLOAD: max_payload_r <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[design/fpp_fifo.sv]
`timescale 1ns / 1ps

module fpp_fifo
  import fpp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  input  logic  pop,
  output desc_t head,
  output logic  full,
  output logic  empty
);

  desc_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/fpp_back.sv]
`timescale 1ns / 1ps

module fpp_back
  import fpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  store_wr_t store_wr,
  input  desc_t     q_head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      busy,
  fpp_out_if.source out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_t;

  typedef struct packed {
    desc_t      d;
    logic [7:0] payload_byte;
    logic       last;
  } result_t;

  logic [7:0]       store [PAYLOAD_DEPTH];
  logic [7:0]       rd_data_r;
  state_t           state_r, state_nxt;
  desc_t            cur_r, cur_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;
  logic             out_free;
  logic             is_last;

  assign out_free = !out_valid_r || out_ch.ready;
  assign is_last  = ((k_r + 1'b1) == cur_r.pay_len);
  assign busy     = (state_r != S_IDLE);

  // payload store, read data registered
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[store_wr.addr] <= store_wr.data;
    end
    rd_data_r <= store[k_r[ADDR_W-1:0]];
  end

  // replay sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.status == ST_READY && q_head.pay_len != '0) begin
            cur_nxt   = q_head;
            k_nxt     = '0;
            state_nxt = S_READ;
          end else begin
            out_valid_nxt        = 1'b1;
            res_nxt.d            = q_head;
            res_nxt.payload_byte = 8'h00;
            res_nxt.last         = 1'b1;
          end
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          res_nxt.d            = cur_r;
          res_nxt.payload_byte = rd_data_r;
          res_nxt.last         = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
    cur_r <= cur_nxt;
    res_r <= res_nxt;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.status              = res_r.d.status;
  assign out_ch.msg_id              = res_r.d.msg_id;
  assign out_ch.sequence_number     = res_r.d.sequence_number;
  assign out_ch.pay_len             = res_r.d.pay_len;
  assign out_ch.payload_byte        = res_r.payload_byte;
  assign out_ch.last                = res_r.last;
  assign out_ch.discarded_count     = res_r.d.counters[CNT_DISCARD];
  assign out_ch.length_error_count  = res_r.d.counters[CNT_LENERR];
  assign out_ch.crc_error_count     = res_r.d.counters[CNT_CRCERR];
  assign out_ch.version_error_count = res_r.d.counters[CNT_VERERR];
  assign out_ch.valid_frame_count   = res_r.d.counters[CNT_VALID];

`ifndef SYNTHESIS
  // a store read always completes before the byte is emitted
  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_EMIT))
    else $error("replay read not followed by emit");

  // replay only runs for a good frame with a payload
  a_replay_desc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (cur_r.status == ST_READY && cur_r.pay_len != '0))
    else $error("replay of a frame that is not ready");

  // replay index stays inside the frame
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (k_r < cur_r.pay_len))
    else $error("replay index past payload length");

  // nothing leaves the queue during a replay
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_pop)
    else $error("queue popped during replay");
`endif

endmodule

[tb/sv/tb_framed_packet_parser_crc16_top.sv]
`timescale 1ns / 1ps

module tb_framed_packet_parser_crc16_top;
  import fpp_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  fpp_in_if  in_if ();
  fpp_out_if out_if ();

  framed_packet_parser_crc16_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // parser position within a frame
  typedef enum logic [3:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    GET_VERSION,
    GET_MSG_ID,
    GET_SEQ,
    GET_LEN,
    GET_PAYLOAD,
    GET_CRC_LO,
    GET_CRC_HI
  } hunt_state_t;

  // one result as it should appear on the output channel
  typedef struct packed {
    status_t                       status;
    logic [7:0]                    msg_id;
    logic [7:0]                    sequence_number;
    logic [LEN_W-1:0]              pay_len;
    logic [7:0]                    payload_byte;
    logic                          last;
    logic [NUM_CNT-1:0][CNT_W-1:0] counters;
  } parse_result_t;

  // register copies
  logic [7:0] sof_first_q;
  logic [7:0] sof_second_q;
  logic [7:0] version_q;
  logic [6:0] max_payload_q;

  // parser copy
  hunt_state_t                   hunt_state;
  logic [6:0]                    pay_pos;
  logic [15:0]                   crc_acc;
  logic [15:0]                   crc_rx;
  logic [7:0]                    hdr_version;
  logic [7:0]                    hdr_msg_id;
  logic [7:0]                    hdr_seq;
  logic [6:0]                    hdr_len;
  logic [7:0]                    pay_mem [PAYLOAD_DEPTH];
  logic [NUM_CNT-1:0][CNT_W-1:0] event_cnt;

  parse_result_t awaited_results[$];
  logic [7:0]    rx_bytes[$];
  int            bytes_queued;
  int            fail_count;
  int            send_idle_pct;
  int            recv_stall_pct;
  logic          hold_start;
  int            hold_left;

  // clock
  always begin
    #10 clk = ~clk;
  end

  // crc-16 ccitt-false, one bit at a time from the msb of the byte
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic restart_hunt_model();
    hunt_state = HUNT_FIRST;
    pay_pos    = '0;
    crc_acc    = CRC_INIT;
    crc_rx     = '0;
  endtask

  // advance the parser copy by one byte and queue the results it causes
  task automatic parse_rx_byte(input logic [7:0] b);
    status_t       st;
    int unsigned   lim;
    parse_result_t r;
    st  = ST_NONE;
    lim = (max_payload_q > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : max_payload_q;
    case (hunt_state)
      HUNT_FIRST: begin
        if (b == sof_first_q) hunt_state = HUNT_SECOND;
        else event_cnt[CNT_DISCARD] += 1;
      end
      HUNT_SECOND: begin
        // second sof wins when both sof values are equal
        if (b == sof_second_q) begin
          hunt_state = GET_VERSION;
          crc_acc    = CRC_INIT;
        end else if (b != sof_first_q) begin
          event_cnt[CNT_DISCARD] += 1;
          hunt_state = HUNT_FIRST;
        end
      end
      GET_VERSION: begin
        hdr_version = b;
        crc_acc     = crc16_step(crc_acc, b);
        hunt_state  = GET_MSG_ID;
      end
      GET_MSG_ID: begin
        hdr_msg_id = b;
        crc_acc    = crc16_step(crc_acc, b);
        hunt_state = GET_SEQ;
      end
      GET_SEQ: begin
        hdr_seq    = b;
        crc_acc    = crc16_step(crc_acc, b);
        hunt_state = GET_LEN;
      end
      GET_LEN: begin
        crc_acc = crc16_step(crc_acc, b);
        pay_pos = '0;
        if (b > lim) begin
          hdr_len = '0;
          event_cnt[CNT_LENERR] += 1;
          restart_hunt_model();
          st = ST_LENERR;
        end else begin
          hdr_len    = b[6:0];
          hunt_state = (b == 8'd0) ? GET_CRC_LO : GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        pay_mem[pay_pos[5:0]] = b;
        pay_pos = pay_pos + 7'd1;
        crc_acc = crc16_step(crc_acc, b);
        if (pay_pos >= hdr_len) hunt_state = GET_CRC_LO;
      end
      GET_CRC_LO: begin
        crc_rx     = {8'h00, b};
        hunt_state = GET_CRC_HI;
      end
      GET_CRC_HI: begin
        crc_rx[15:8] = b;
        // crc mismatch takes priority over a version mismatch
        if (crc_rx != crc_acc) begin
          event_cnt[CNT_CRCERR] += 1;
          st = ST_CRCERR;
        end else if (hdr_version != version_q) begin
          event_cnt[CNT_VERERR] += 1;
          st = ST_VERERR;
        end else begin
          event_cnt[CNT_VALID] += 1;
          st = ST_READY;
        end
        restart_hunt_model();
      end
      default: restart_hunt_model();
    endcase

    r          = '0;
    r.status   = st;
    r.counters = event_cnt;
    r.last     = 1'b1;
    if (st == ST_READY && hdr_len != 0) begin
      // one result per stored payload byte
      r.msg_id          = hdr_msg_id;
      r.sequence_number = hdr_seq;
      r.pay_len         = hdr_len;
      for (int k = 0; k < hdr_len; k++) begin
        r.payload_byte = pay_mem[k];
        r.last         = (k == hdr_len - 1);
        awaited_results.push_back(r);
      end
    end else begin
      if (st == ST_READY) begin
        r.msg_id          = hdr_msg_id;
        r.sequence_number = hdr_seq;
      end
      awaited_results.push_back(r);
    end
  endtask

  task automatic compare_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    end
  endtask

  // input driver: pops queued bytes, random gaps between transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.rx_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_rx_byte(in_if.rx_byte);
      end
      if (!in_if.valid || in_if.ready) begin
        if (rx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid   <= 1'b1;
          in_if.rx_byte <= rx_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted down on its own
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor: checks each result transaction against the oldest expectation
  always @(posedge clk) begin
    parse_result_t exp_r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, out_if.status);
        end else begin
          exp_r = awaited_results.pop_front();
          compare_field("status", exp_r.status, out_if.status);
          compare_field("msg_id", exp_r.msg_id, out_if.msg_id);
          compare_field("sequence_number", exp_r.sequence_number, out_if.sequence_number);
          compare_field("pay_len", exp_r.pay_len, out_if.pay_len);
          compare_field("payload_byte", exp_r.payload_byte, out_if.payload_byte);
          compare_field("last", exp_r.last, out_if.last);
          compare_field("discarded_count", exp_r.counters[CNT_DISCARD],
                        out_if.discarded_count);
          compare_field("length_error_count", exp_r.counters[CNT_LENERR],
                        out_if.length_error_count);
          compare_field("crc_error_count", exp_r.counters[CNT_CRCERR],
                        out_if.crc_error_count);
          compare_field("version_error_count", exp_r.counters[CNT_VERERR],
                        out_if.version_error_count);
          compare_field("valid_frame_count", exp_r.counters[CNT_VALID],
                        out_if.valid_frame_count);
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic put_byte(input logic [7:0] b);
    rx_bytes.push_back(b);
    bytes_queued++;
  endtask

  // wait until every queued byte is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_bytes.size() != 0 || in_if.valid || awaited_results.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SOF_FIRST:   sof_first_q   = val;
      CFG_SOF_SECOND:  sof_second_q  = val;
      CFG_EXP_VERSION: version_q     = val;
      CFG_MAX_PAYLOAD: max_payload_q = val[6:0];
      default: ;
    endcase
  endtask

  // registers change only with the block drained
  task automatic reconfigure(input logic [7:0] sof1, input logic [7:0] sof2,
                             input logic [7:0] ver, input logic [7:0] max_len);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(CFG_SOF_FIRST, sof1);
    write_reg(CFG_SOF_SECOND, sof2);
    write_reg(CFG_EXP_VERSION, ver);
    write_reg(CFG_MAX_PAYLOAD, max_len);
  endtask

  // build a frame with the current sof values, optionally corrupted or cut short
  task automatic queue_frame(input logic [7:0] ver, input logic [7:0] mid,
                             input logic [7:0] seq, input logic [7:0] len,
                             input logic [15:0] crc_flip, input int extra_sof,
                             input int cut);
    logic [7:0]  frame_b[$];
    logic [7:0]  p;
    logic [15:0] crc;
    int unsigned lim;
    lim = (max_payload_q > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : max_payload_q;
    repeat (extra_sof) frame_b.push_back(sof_first_q);
    frame_b.push_back(sof_first_q);
    frame_b.push_back(sof_second_q);
    crc = CRC_INIT;
    frame_b.push_back(ver);
    crc = crc16_step(crc, ver);
    frame_b.push_back(mid);
    crc = crc16_step(crc, mid);
    frame_b.push_back(seq);
    crc = crc16_step(crc, seq);
    frame_b.push_back(len);
    crc = crc16_step(crc, len);
    if (len <= lim) begin
      for (int i = 0; i < len; i++) begin
        p = 8'($urandom);
        frame_b.push_back(p);
        crc = crc16_step(crc, p);
      end
      crc = crc ^ crc_flip;
      frame_b.push_back(crc[7:0]);
      frame_b.push_back(crc[15:8]);
    end
    for (int i = 0; i < frame_b.size() && i < cut; i++) begin
      put_byte(frame_b[i]);
    end
  endtask

  // mostly well-formed frames with random content, some noise and cut frames
  task automatic queue_random_traffic(input int n_bytes);
    int          stop_at;
    int          pick;
    int          len_pick;
    int unsigned lim;
    int unsigned len;
    int          extra;
    logic [15:0] flip;
    logic [7:0]  ver;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      lim  = (max_payload_q > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : max_payload_q;
      pick = $urandom_range(99);
      if (pick < 72) begin
        len_pick = $urandom_range(99);
        if (len_pick < 75) len = $urandom_range((lim < 10) ? lim : 10, 0);
        else if (len_pick < 88) len = $urandom_range(lim, 0);
        else len = $urandom_range(255, lim + 1);
        flip  = ($urandom_range(99) < 15) ? 16'($urandom_range(65535, 1)) : 16'h0000;
        extra = ($urandom_range(99) < 20) ? $urandom_range(2, 1) : 0;
        ver   = ($urandom_range(99) < 85) ? version_q : 8'($urandom);
        queue_frame(ver, 8'($urandom), 8'($urandom), 8'(len), flip, extra, 1000);
      end else if (pick < 88) begin
        repeat ($urandom_range(5, 1)) put_byte(8'($urandom));
      end else begin
        queue_frame(version_q, 8'($urandom), 8'($urandom), 8'($urandom_range(lim, 0)),
                    16'h0000, 0, int'($urandom_range(8, 1)));
      end
    end
  endtask

  // run limit
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // stimulus sequence
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SOF_FIRST;
    cfg_data       = 8'h00;
    hold_start     = 1'b0;
    fail_count     = 0;
    bytes_queued   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // parser copy at reset
    sof_first_q   = 8'hAA;
    sof_second_q  = 8'h55;
    version_q     = 8'h01;
    max_payload_q = 7'd64;
    restart_hunt_model();
    hdr_version = '0;
    hdr_msg_id  = '0;
    hdr_seq     = '0;
    hdr_len     = '0;
    event_cnt   = '0;
    foreach (pay_mem[i]) pay_mem[i] = 8'h00;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: repeated first sof with empty payload, oversize length,
    // crc and version both wrong
    queue_frame(8'h01, 8'hFF, 8'h00, 8'd0, 16'h0000, 1, 1000);
    queue_frame(8'h01, 8'h00, 8'hFF, 8'hFF, 16'h0000, 0, 1000);
    queue_frame(8'h00, 8'h5A, 8'hA5, 8'd0, 16'h0001, 0, 1000);
    wait_drained();
    queue_random_traffic(20);

    // full-size payload, sender mostly idle
    reconfigure(8'h00, 8'hFF, 8'hFF, 8'd64);
    send_idle_pct = 85;
    queue_frame(version_q, 8'($urandom), 8'($urandom), 8'd64, 16'h0000, 0, 1000);
    queue_random_traffic(25);

    // equal sof values, zero payload limit, receiver mostly stalled
    reconfigure(8'h7E, 8'h7E, 8'h00, 8'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    queue_frame(version_q, 8'($urandom), 8'($urandom), 8'd0, 16'h0000, 0, 1000);
    queue_frame(version_q, 8'($urandom), 8'($urandom), 8'd1, 16'h0000, 0, 1000);
    queue_random_traffic(20);

    // small limit, both sides idling
    reconfigure(8'hAA, 8'h55, 8'h01, 8'd8);
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    queue_frame(version_q, 8'($urandom), 8'($urandom), 8'd8, 16'h0000, 0, 1000);
    queue_frame(version_q, 8'($urandom), 8'($urandom), 8'd9, 16'h0000, 0, 1000);
    queue_random_traffic(20);

    // receiver holds off while the sender keeps offering bytes
    wait_drained();
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start    <= 1'b0;
    send_idle_pct = 0;
    queue_random_traffic(20);
    wait_drained();

    // limit just under the store depth, no idling
    reconfigure(8'hFF, 8'h00, 8'($urandom), 8'd63);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_frame(version_q, 8'($urandom), 8'($urandom), 8'd63, 16'h0000, 0, 1000);
    queue_random_traffic(20);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
